// File: sv/idhp_pkg.sv
package idhp_pkg;

    localparam int unsigned ByteW    = 8;
    localparam int unsigned DimW     = 32;
    localparam int unsigned OutDataW = 80;

    // Largest dimension that counts as usable.
    localparam logic [DimW-1:0] DimMax = 32'd32767;

    localparam logic [ByteW-1:0] PngFirst  = 8'h89;
    localparam logic [ByteW-1:0] MarkFill  = 8'hFF;
    localparam logic [ByteW-1:0] MarkSoi   = 8'hD8;
    localparam logic [ByteW-1:0] MarkEoi   = 8'hD9;
    localparam logic [ByteW-1:0] MarkSos   = 8'hDA;
    localparam logic [ByteW-1:0] MarkTem   = 8'h01;
    localparam logic [ByteW-1:0] MarkRst0  = 8'hD0;
    localparam logic [ByteW-1:0] MarkDht   = 8'hC4;
    localparam logic [ByteW-1:0] MarkJpg   = 8'hC8;
    localparam logic [ByteW-1:0] MarkDac   = 8'hCC;
    localparam logic [ByteW-1:0] MarkSof0  = 8'hC0;
    localparam logic [ByteW-1:0] MarkSof15 = 8'hCF;

    typedef struct packed {
        logic             start_of_file;
        logic [ByteW-1:0] byte_value;
    } t_in_item;

    typedef struct packed {
        logic             accepted;
        logic             finished;
        logic             failed;
        logic             is_png;
        logic [DimW-1:0]  image_width;
        logic [DimW-1:0]  image_height;
        logic             dims_valid;
        logic [ByteW-1:0] frame_marker;
    } t_result;

    function automatic logic [ByteW-1:0] png_sig_byte(input logic [2:0] idx);
        logic [ByteW-1:0] v;
        case (idx)
            3'd0:    v = 8'h89;
            3'd1:    v = 8'h50;
            3'd2:    v = 8'h4E;
            3'd3:    v = 8'h47;
            3'd4:    v = 8'h0D;
            3'd5:    v = 8'h0A;
            3'd6:    v = 8'h1A;
            default: v = 8'h0A;
        endcase
        return v;
    endfunction

    function automatic logic [ByteW-1:0] ihdr_byte(input logic [1:0] idx);
        logic [ByteW-1:0] v;
        case (idx)
            2'd0:    v = 8'h49;
            2'd1:    v = 8'h48;
            2'd2:    v = 8'h44;
            default: v = 8'h52;
        endcase
        return v;
    endfunction

    function automatic logic is_frame_marker(input logic [ByteW-1:0] m);
        return (m >= MarkSof0) && (m <= MarkSof15) &&
               (m != MarkDht) && (m != MarkJpg) && (m != MarkDac);
    endfunction

endpackage

// File: sv/idhp_in_reg.sv
module idhp_in_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  idhp_pkg::t_in_item i_item,
    input  logic              i_advance,
    output logic              o_ready,
    output logic              o_valid,
    output idhp_pkg::t_in_item o_item
);
    import idhp_pkg::*;

    logic     r_valid;
    t_in_item r_item;

    assign o_ready = !r_valid || i_advance;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule

// File: sv/idhp_parser.sv
module idhp_parser (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_advance,
    input  idhp_pkg::t_in_item i_item,
    output idhp_pkg::t_result  o_result
);
    import idhp_pkg::*;

    typedef enum logic [10:0] {
        PH_SNIFF  = 11'b000_0000_0001,
        PH_PNG    = 11'b000_0000_0010,
        PH_SOI    = 11'b000_0000_0100,
        PH_FF     = 11'b000_0000_1000,
        PH_MARKER = 11'b000_0001_0000,
        PH_LENHI  = 11'b000_0010_0000,
        PH_LENLO  = 11'b000_0100_0000,
        PH_SKIP   = 11'b000_1000_0000,
        PH_SOF    = 11'b001_0000_0000,
        PH_DONE   = 11'b010_0000_0000,
        PH_FAILED = 11'b100_0000_0000
    } t_phase;

    t_phase           r_phase,   n_phase,   c_phase;
    logic [4:0]       r_pos,     n_pos,     c_pos;
    logic [DimW-1:0]  r_width,   n_width,   c_width;
    logic [DimW-1:0]  r_height,  n_height,  c_height;
    logic [ByteW-1:0] r_len_hi,  n_len_hi,  c_len_hi;
    logic [15:0]      r_skip,    n_skip,    c_skip;
    logic             r_pending, n_pending, c_pending;
    logic [ByteW-1:0] r_marker,  n_marker,  c_marker;
    logic [2:0]       r_fill,    n_fill,    c_fill;
    logic             r_png,     n_png,     c_png;
    // Frame header bytes 1..3 (height hi/lo, width hi); byte 4 is taken live.
    logic [ByteW-1:0] r_hdr [3];

    logic [ByteW-1:0] b;
    logic [15:0]      seg_len;
    logic             acc;
    logic             done;

    assign b       = i_item.byte_value;
    assign seg_len = {c_len_hi, b};

    // A start-of-file transaction sees the reset state.
    always_comb begin
        if (i_item.start_of_file) begin
            c_phase   = PH_SNIFF;
            c_pos     = '0;
            c_width   = '0;
            c_height  = '0;
            c_len_hi  = '0;
            c_skip    = '0;
            c_pending = 1'b0;
            c_marker  = '0;
            c_fill    = '0;
            c_png     = 1'b0;
        end else begin
            c_phase   = r_phase;
            c_pos     = r_pos;
            c_width   = r_width;
            c_height  = r_height;
            c_len_hi  = r_len_hi;
            c_skip    = r_skip;
            c_pending = r_pending;
            c_marker  = r_marker;
            c_fill    = r_fill;
            c_png     = r_png;
        end
    end

    always_comb begin
        n_phase   = c_phase;
        n_pos     = c_pos;
        n_width   = c_width;
        n_height  = c_height;
        n_len_hi  = c_len_hi;
        n_skip    = c_skip;
        n_pending = c_pending;
        n_marker  = c_marker;
        n_fill    = c_fill;
        n_png     = c_png;
        acc       = 1'b0;
        case (c_phase)
            PH_SNIFF: begin
                n_pos = 5'd1;
                acc   = 1'b1;
                if (b == MarkFill) begin
                    n_phase = PH_SOI;
                end else if (b == PngFirst) begin
                    n_phase = PH_PNG;
                    n_png   = 1'b1;
                end else begin
                    n_phase = PH_FAILED;
                    acc     = 1'b0;
                end
            end
            PH_PNG: begin
                n_pos = c_pos + 5'd1;
                acc   = 1'b1;
                if (c_pos < 5'd8) begin
                    if (b != png_sig_byte(c_pos[2:0])) begin
                        n_phase = PH_FAILED;
                        n_pos   = c_pos;
                        acc     = 1'b0;
                    end
                end else if (c_pos >= 5'd12 && c_pos < 5'd16) begin
                    if (b != ihdr_byte(c_pos[1:0])) begin
                        n_phase = PH_FAILED;
                        n_pos   = c_pos;
                        acc     = 1'b0;
                    end
                end else if (c_pos >= 5'd16 && c_pos < 5'd20) begin
                    n_width = {c_width[DimW-ByteW-1:0], b};
                end else if (c_pos >= 5'd20 && c_pos < 5'd24) begin
                    n_height = {c_height[DimW-ByteW-1:0], b};
                    if (c_pos == 5'd23) begin
                        n_phase = PH_DONE;
                        acc     = 1'b0;
                    end
                end
            end
            PH_SOI: begin
                if (b == MarkSoi) begin
                    n_phase = PH_FF;
                    acc     = 1'b1;
                end else begin
                    n_phase = PH_FAILED;
                end
            end
            PH_FF: begin
                if (b == MarkFill) begin
                    n_phase = PH_MARKER;
                    acc     = 1'b1;
                end else begin
                    n_phase = PH_FAILED;
                end
            end
            PH_MARKER: begin
                acc = 1'b1;
                if (b == MarkFill) begin
                    n_phase = PH_MARKER;
                end else if (b == MarkTem || (b >= MarkRst0 && b <= MarkSoi)) begin
                    n_phase = PH_FF;
                end else if (b == MarkEoi || b == MarkSos) begin
                    n_phase = PH_FAILED;
                    acc     = 1'b0;
                end else begin
                    n_pending = is_frame_marker(b);
                    if (is_frame_marker(b)) begin
                        n_marker = b;
                    end
                    n_phase = PH_LENHI;
                end
            end
            PH_LENHI: begin
                n_len_hi = b;
                n_phase  = PH_LENLO;
                acc      = 1'b1;
            end
            PH_LENLO: begin
                acc = 1'b1;
                if (seg_len < 16'd2 || (c_pending && seg_len < 16'd7)) begin
                    n_phase = PH_FAILED;
                    acc     = 1'b0;
                end else if (c_pending) begin
                    n_fill  = '0;
                    n_phase = PH_SOF;
                end else if (seg_len == 16'd2) begin
                    n_phase = PH_FF;
                end else begin
                    n_skip  = seg_len - 16'd2;
                    n_phase = PH_SKIP;
                end
            end
            PH_SKIP: begin
                acc    = 1'b1;
                n_skip = c_skip - 16'd1;
                if (c_skip == 16'd1) begin
                    n_phase = PH_FF;
                end
            end
            PH_SOF: begin
                acc    = 1'b1;
                n_fill = c_fill + 3'd1;
                if (c_fill == 3'd4) begin
                    n_height = {{(DimW-2*ByteW){1'b0}}, r_hdr[0], r_hdr[1]};
                    n_width  = {{(DimW-2*ByteW){1'b0}}, r_hdr[2], b};
                    n_phase  = PH_DONE;
                    acc      = 1'b0;
                end
            end
            default: begin
                acc = 1'b0;
            end
        endcase
    end

    assign done = (n_phase == PH_DONE);

    always_comb begin
        o_result.accepted     = acc;
        o_result.finished     = done;
        o_result.failed       = (n_phase == PH_FAILED);
        o_result.is_png       = n_png;
        o_result.image_width  = n_width;
        o_result.image_height = n_height;
        o_result.dims_valid   = done && (n_width != '0) && (n_height != '0) &&
                                (n_width <= DimMax) && (n_height <= DimMax);
        o_result.frame_marker = done ? n_marker : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_SNIFF;
            r_pos     <= '0;
            r_width   <= '0;
            r_height  <= '0;
            r_len_hi  <= '0;
            r_skip    <= '0;
            r_pending <= 1'b0;
            r_marker  <= '0;
            r_fill    <= '0;
            r_png     <= 1'b0;
        end else if (i_advance) begin
            r_phase   <= n_phase;
            r_pos     <= n_pos;
            r_width   <= n_width;
            r_height  <= n_height;
            r_len_hi  <= n_len_hi;
            r_skip    <= n_skip;
            r_pending <= n_pending;
            r_marker  <= n_marker;
            r_fill    <= n_fill;
            r_png     <= n_png;
        end
    end

    // Header byte 0 (precision) is never needed, so only bytes 1..3 are kept.
    always_ff @(posedge i_clk) begin
        if (i_advance && c_phase == PH_SOF && c_fill >= 3'd1 && c_fill <= 3'd3) begin
            r_hdr[2'(c_fill - 3'd1)] <= b;
        end
    end

endmodule

// File: sv/idhp_out_reg.sv
module idhp_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  idhp_pkg::t_result i_result,
    input  logic              i_ready,
    output logic              o_can_load,
    output logic              o_valid,
    output idhp_pkg::t_result o_result
);
    import idhp_pkg::*;

    logic    r_valid;
    t_result r_result;

    assign o_can_load = !r_valid || i_ready;
    assign o_valid    = r_valid;
    assign o_result   = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_can_load) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

endmodule

// File: sv/image_header_dims_probe_top.sv
// Path: a byte is loaded into the input register at the edge that accepts it,
// and its result is loaded into the result register when that register can
// take it. Throughput: one byte per cycle unless the result output is stalled;
// the parser state is updated by a single step between the input register
// and the result register. Reset: synchronous, active low; clears the
// handshake registers and all parser state except r_hdr. A start-of-file flag
// in tuser clears the parser state for that byte.
module image_header_dims_probe_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,  // [7:0] byte_value
    input  logic [0:0]  i_s_axis_tuser,  // [0] start_of_file
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [0] accepted, [1] finished, [2] failed, [3] is_png, [35:4] image_width,
    // [67:36] image_height, [68] dims_valid, [76:69] frame_marker, [79:77] zero
    output logic [79:0] o_m_axis_tdata
);
    import idhp_pkg::*;

    t_in_item in_item;
    t_in_item reg_item;
    t_result  parse_res;
    t_result  out_res;
    logic     reg_valid;
    logic     can_load;
    logic     advance;

    assign in_item.byte_value    = i_s_axis_tdata;
    assign in_item.start_of_file = i_s_axis_tuser[0];
    assign advance               = reg_valid && can_load;

    idhp_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_s_axis_tvalid),
        .i_item    (in_item),
        .i_advance (advance),
        .o_ready   (o_s_axis_tready),
        .o_valid   (reg_valid),
        .o_item    (reg_item)
    );

    idhp_parser u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_item    (reg_item),
        .o_result  (parse_res)
    );

    idhp_out_reg u_out_reg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (advance),
        .i_result   (parse_res),
        .i_ready    (i_m_axis_tready),
        .o_can_load (can_load),
        .o_valid    (o_m_axis_tvalid),
        .o_result   (out_res)
    );

    assign o_m_axis_tdata = {3'b000,
                             out_res.frame_marker,
                             out_res.dims_valid,
                             out_res.image_height,
                             out_res.image_width,
                             out_res.is_png,
                             out_res.failed,
                             out_res.finished,
                             out_res.accepted};

    // Input side only stalls when a result is held back downstream.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> (o_m_axis_tvalid && !i_m_axis_tready))
        else $error("input stalled without a held result");

    a_done_xor_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> !(o_m_axis_tdata[1] && o_m_axis_tdata[2]))
        else $error("finished and failed both set");

    a_valid_needs_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tdata[68]) |->
            (o_m_axis_tdata[1] && !o_m_axis_tdata[0]))
        else $error("dims_valid without a finished parse");

    a_marker_jpeg_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tdata[76:69] != 8'h00) |->
            (o_m_axis_tdata[1] && !o_m_axis_tdata[3]))
        else $error("frame marker reported outside a finished JPEG parse");

endmodule

// File: test/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import idhp_pkg::*;

    typedef enum logic [3:0] {
        PH_SNIFF, PH_PNG, PH_SOI, PH_FF, PH_MARKER, PH_LENHI,
        PH_LENLO, PH_SKIP, PH_SOF, PH_DONE, PH_FAILED
    } t_probe_phase;

    localparam logic [7:0] PNG_MAGIC [0:7] = '{8'h89, 8'h50, 8'h4E, 8'h47,
                                               8'h0D, 8'h0A, 8'h1A, 8'h0A};
    localparam logic [7:0] IHDR_TAG  [0:3] = '{8'h49, 8'h48, 8'h44, 8'h52};

    class dims_scoreboard;
        t_result      expected_q[$];
        int unsigned  errors;
        int unsigned  checked;
        int unsigned  live_bytes;

        t_probe_phase phase;
        logic [4:0]   pos;
        logic [31:0]  width_acc;
        logic [31:0]  height_acc;
        logic [15:0]  seg_len;
        logic [15:0]  skip_left;
        logic         in_frame;
        logic [7:0]   sof_marker;
        logic [7:0]   sof_hdr [5];
        logic [2:0]   sof_count;
        logic         png_seen;

        function new();
            errors     = 0;
            checked    = 0;
            live_bytes = 0;
            clear();
        endfunction

        function void clear();
            phase      = PH_SNIFF;
            pos        = '0;
            width_acc  = '0;
            height_acc = '0;
            seg_len    = '0;
            skip_left  = '0;
            in_frame   = 1'b0;
            sof_marker = '0;
            sof_count  = '0;
            png_seen   = 1'b0;
            foreach (sof_hdr[i]) sof_hdr[i] = '0;
        endfunction

        // Advances the parser by one byte; the return value says whether more bytes are wanted.
        function logic parse(input logic [7:0] b);
            logic [4:0] p;
            p = pos;
            case (phase)
                PH_SNIFF: begin
                    if (b == MarkFill) begin
                        phase = PH_SOI;
                    end else if (b == PngFirst) begin
                        phase    = PH_PNG;
                        png_seen = 1'b1;
                    end else begin
                        phase = PH_FAILED;
                        return 1'b0;
                    end
                    pos = 5'd1;
                    return 1'b1;
                end
                PH_PNG: begin
                    if (p < 5'd8) begin
                        if (b != PNG_MAGIC[p[2:0]]) begin
                            phase = PH_FAILED;
                            return 1'b0;
                        end
                    end else if (p >= 5'd12 && p < 5'd16) begin
                        if (b != IHDR_TAG[p[1:0]]) begin
                            phase = PH_FAILED;
                            return 1'b0;
                        end
                    end else if (p >= 5'd16 && p < 5'd20) begin
                        width_acc = {width_acc[23:0], b};
                    end else if (p >= 5'd20 && p < 5'd24) begin
                        height_acc = {height_acc[23:0], b};
                        if (p == 5'd23) begin
                            phase = PH_DONE;
                            pos   = p + 5'd1;
                            return 1'b0;
                        end
                    end
                    pos = p + 5'd1;
                    return 1'b1;
                end
                PH_SOI: begin
                    if (b != MarkSoi) begin
                        phase = PH_FAILED;
                        return 1'b0;
                    end
                    phase = PH_FF;
                    return 1'b1;
                end
                PH_FF: begin
                    if (b != MarkFill) begin
                        phase = PH_FAILED;
                        return 1'b0;
                    end
                    phase = PH_MARKER;
                    return 1'b1;
                end
                PH_MARKER: begin
                    if (b == MarkFill) return 1'b1;
                    if (b == MarkTem || (b >= MarkRst0 && b <= MarkSoi)) begin
                        phase = PH_FF;
                        return 1'b1;
                    end
                    if (b == MarkEoi || b == MarkSos) begin
                        phase = PH_FAILED;
                        return 1'b0;
                    end
                    in_frame = (b[7:4] == 4'hC) && (b != MarkDht) && (b != MarkJpg) &&
                               (b != MarkDac);
                    if (in_frame) sof_marker = b;
                    phase = PH_LENHI;
                    return 1'b1;
                end
                PH_LENHI: begin
                    seg_len = {b, 8'h00};
                    phase   = PH_LENLO;
                    return 1'b1;
                end
                PH_LENLO: begin
                    seg_len = {seg_len[15:8], b};
                    if (seg_len < 16'd2 || (in_frame && seg_len < 16'd7)) begin
                        phase = PH_FAILED;
                        return 1'b0;
                    end
                    if (in_frame) begin
                        sof_count = '0;
                        phase     = PH_SOF;
                    end else if (seg_len == 16'd2) begin
                        phase = PH_FF;
                    end else begin
                        skip_left = seg_len - 16'd2;
                        phase     = PH_SKIP;
                    end
                    return 1'b1;
                end
                PH_SKIP: begin
                    skip_left = skip_left - 16'd1;
                    if (skip_left == '0) phase = PH_FF;
                    return 1'b1;
                end
                PH_SOF: begin
                    sof_hdr[sof_count] = b;
                    sof_count = sof_count + 3'd1;
                    if (sof_count >= 3'd5) begin
                        height_acc = {16'h0000, sof_hdr[1], sof_hdr[2]};
                        width_acc  = {16'h0000, sof_hdr[3], sof_hdr[4]};
                        phase      = PH_DONE;
                        return 1'b0;
                    end
                    return 1'b1;
                end
                default: return 1'b0;
            endcase
        endfunction

        function void note_input(input logic [7:0] b, input logic sof);
            t_result exp_r;
            logic    done;
            if (sof) clear();
            if (phase != PH_DONE && phase != PH_FAILED) live_bytes++;
            exp_r.accepted     = parse(b);
            done               = (phase == PH_DONE);
            exp_r.finished     = done;
            exp_r.failed       = (phase == PH_FAILED);
            exp_r.is_png       = png_seen;
            exp_r.image_width  = width_acc;
            exp_r.image_height = height_acc;
            exp_r.dims_valid   = done && width_acc != '0 && height_acc != '0 &&
                                 width_acc <= DimMax && height_acc <= DimMax;
            exp_r.frame_marker = done ? sof_marker : '0;
            expected_q.push_back(exp_r);
        endfunction

        function void compare(input string name, input logic [31:0] e, input logic [31:0] a);
            if (e !== a) begin
                errors++;
                $display("%0t mismatch on %s: expected %0h, actual %0h", $time, name, e, a);
            end
        endfunction

        function void check_result(input logic [79:0] d);
            t_result exp_r;
            if (expected_q.size() == 0) begin
                errors++;
                $display("%0t result transaction with nothing expected: actual %h", $time, d);
                return;
            end
            exp_r = expected_q.pop_front();
            checked++;
            compare("accepted",     {31'd0, exp_r.accepted},   {31'd0, d[0]});
            compare("finished",     {31'd0, exp_r.finished},   {31'd0, d[1]});
            compare("failed",       {31'd0, exp_r.failed},     {31'd0, d[2]});
            compare("is_png",       {31'd0, exp_r.is_png},     {31'd0, d[3]});
            compare("image_width",  exp_r.image_width,         d[35:4]);
            compare("image_height", exp_r.image_height,        d[67:36]);
            compare("dims_valid",   {31'd0, exp_r.dims_valid}, {31'd0, d[68]});
            compare("frame_marker", {24'd0, exp_r.frame_marker}, {24'd0, d[76:69]});
        endfunction

        function int unsigned outstanding();
            return expected_q.size();
        endfunction
    endclass

    localparam int unsigned CycleLimit = 1000000;
    localparam int unsigned ByteTarget = 1400;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [7:0]  i_s_axis_tdata = '0;
    logic [0:0]  i_s_axis_tuser = '0;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [79:0] o_m_axis_tdata;

    dims_scoreboard sb = new();
    logic [7:0]     file_bytes[$];
    bit             burst = 1'b0;
    bit             draining = 1'b0;
    int unsigned    cycles = 0;

    image_header_dims_probe_top DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [15:0] pick_dim16();
        int unsigned r;
        r = $urandom_range(0, 9);
        case (r)
            0:       return 16'd0;
            1:       return 16'd1;
            2:       return 16'd32767;
            3:       return 16'd32768;
            4:       return 16'hFFFF;
            5:       return 16'($urandom_range(0, 65535));
            default: return 16'($urandom_range(1, 2000));
        endcase
    endfunction

    function automatic logic [31:0] pick_dim32();
        int unsigned r;
        r = $urandom_range(0, 9);
        case (r)
            0:       return 32'hFFFF_FFFF;
            1:       return $urandom();
            2:       return 32'h0001_0000 | $urandom_range(0, 65535);
            default: return {16'h0000, pick_dim16()};
        endcase
    endfunction

    task automatic add_byte(input logic [7:0] b);
        file_bytes.push_back(b);
    endtask

    task automatic add_be16(input logic [15:0] v);
        add_byte(v[15:8]);
        add_byte(v[7:0]);
    endtask

    task automatic add_be32(input logic [31:0] v);
        add_be16(v[31:16]);
        add_be16(v[15:0]);
    endtask

    task automatic add_junk(input int unsigned n);
        repeat (n) add_byte(8'($urandom_range(0, 255)));
    endtask

    // Extra 0xFF bytes in marker position are padding and must be swallowed.
    task automatic add_fills();
        if ($urandom_range(0, 7) == 0) repeat ($urandom_range(1, 3)) add_byte(MarkFill);
    endtask

    task automatic gen_png(input logic [31:0] w, input logic [31:0] h,
                           input logic [31:0] len_word, input int bad_at);
        logic [7:0] flip;
        for (int i = 0; i < 8; i++) add_byte(PNG_MAGIC[i]);
        add_be32(len_word);
        for (int i = 0; i < 4; i++) add_byte(IHDR_TAG[i]);
        add_be32(w);
        add_be32(h);
        if (bad_at >= 0) begin
            flip = 8'($urandom_range(1, 255));
            file_bytes[bad_at] = file_bytes[bad_at] ^ flip;
        end
    endtask

    task automatic gen_segment(input logic [7:0] m, input logic [15:0] len);
        add_byte(MarkFill);
        add_fills();
        add_byte(m);
        add_be16(len);
        if (len > 16'd2) add_junk(32'(len) - 32'd2);
    endtask

    task automatic gen_sof(input logic [7:0] m, input logic [15:0] len,
                           input logic [15:0] h, input logic [15:0] w);
        add_byte(MarkFill);
        add_fills();
        add_byte(m);
        add_be16(len);
        add_byte(8'($urandom_range(0, 255)));
        add_be16(h);
        add_be16(w);
    endtask

    task automatic gen_jpeg(input bit broken);
        int unsigned flaw;
        int unsigned r;
        logic [7:0]  m;
        logic [15:0] len;
        flaw = broken ? $urandom_range(1, 5) : 0;
        add_byte(MarkFill);
        if (flaw == 1) begin
            do m = 8'($urandom_range(0, 255)); while (m == MarkSoi);
            add_byte(m);
        end else begin
            add_byte(MarkSoi);
        end
        repeat ($urandom_range(0, 3)) begin
            r = $urandom_range(0, 99);
            if (r < 30) begin
                add_byte(MarkFill);
                add_fills();
                if ($urandom_range(0, 3) == 0) add_byte(MarkTem);
                else add_byte(MarkRst0 + 8'($urandom_range(0, 8)));
            end else begin
                case ($urandom_range(0, 6))
                    0:       m = MarkDht;
                    1:       m = MarkJpg;
                    2:       m = MarkDac;
                    3:       m = 8'($urandom_range(8'h02, 8'hBF));
                    4:       m = 8'hDB;
                    default: m = 8'hE0 + 8'($urandom_range(0, 15));
                endcase
                if ($urandom_range(0, 9) == 0) len = 16'h0100 + 16'($urandom_range(0, 20));
                else len = 16'($urandom_range(2, 10));
                gen_segment(m, len);
            end
        end
        case (flaw)
            2: begin
                add_byte(MarkFill);
                add_byte($urandom_range(0, 1) ? MarkEoi : MarkSos);
            end
            3: begin
                add_byte(MarkFill);
                add_byte(8'hE0 + 8'($urandom_range(0, 15)));
                add_be16(16'($urandom_range(0, 1)));
            end
            5: add_byte(8'($urandom_range(0, 254)));
            default: ;
        endcase
        do m = MarkSof0 + 8'($urandom_range(0, 15));
        while (m == MarkDht || m == MarkJpg || m == MarkDac);
        len = (flaw == 4) ? 16'($urandom_range(2, 6)) : 16'($urandom_range(7, 17));
        gen_sof(m, len, pick_dim16(), pick_dim16());
    endtask

    task automatic send_byte(input logic [7:0] b, input logic sof);
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= b;
        i_s_axis_tuser  <= sof;
        do @(posedge i_clk); while (!o_s_axis_tready);
        sb.note_input(b, sof);
    endtask

    task automatic send_file(input logic first_sof);
        int unsigned gap;
        for (int i = 0; i < file_bytes.size(); i++) begin
            send_byte(file_bytes[i], (i == 0) ? first_sof : 1'b0);
            gap = burst ? 0 : pick_gap();
            if (gap > 0) begin
                i_s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        file_bytes.delete();
    endtask

    task automatic wait_all_results();
        i_s_axis_tvalid <= 1'b0;
        while (sb.outstanding() != 0) @(posedge i_clk);
    endtask

    // Result side: random back-pressure, one long hold-off, and free flow while draining.
    initial begin : receiver
        int unsigned stall_left;
        int unsigned hold_left;
        int unsigned calm_left;
        int unsigned r;
        bit          hold_done;
        logic        ready_next;
        stall_left = 0;
        hold_left  = 0;
        calm_left  = 0;
        hold_done  = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready)
                sb.check_result(o_m_axis_tdata);
            if (!hold_done && sb.checked >= 600) begin
                hold_done = 1'b1;
                hold_left = 250;
            end
            if (hold_left > 0) begin
                hold_left--;
                ready_next = 1'b0;
            end else if (draining || calm_left > 0) begin
                if (calm_left > 0) calm_left--;
                ready_next = 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                ready_next = 1'b0;
            end else begin
                r = $urandom_range(0, 99);
                if (r == 0) begin
                    calm_left  = $urandom_range(50, 150);
                    ready_next = 1'b1;
                end else if (r < 80) begin
                    ready_next = 1'b1;
                end else begin
                    ready_next = 1'b0;
                    stall_left = (r < 97) ? $urandom_range(0, 2) : $urandom_range(10, 40);
                end
            end
            i_m_axis_tready <= ready_next;
        end
    end

    initial begin : stimulus
        int unsigned r;
        int          bad_at;
        int unsigned keep;
        bit          paused;
        paused = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed files. The first relies on the reset state alone, without a start flag.
        gen_png(32'hFFFF_FFFF, 32'd1, 32'd13, -1);
        add_junk(2);
        send_file(1'b0);
        gen_png(32'd32767, 32'd32767, 32'd13, -1);
        add_junk(2);
        send_file(1'b1);
        gen_png(32'd0, 32'd5, 32'd13, -1);
        send_file(1'b1);
        gen_png(32'd640, 32'd480, 32'd13, 3);
        send_file(1'b1);
        gen_png(32'd640, 32'd480, 32'd13, 14);
        send_file(1'b1);
        // The IHDR length word is not checked, so any value must pass.
        gen_png(32'd32768, 32'd100, 32'hFFFF_FFFF, -1);
        send_file(1'b1);
        add_byte(8'h00);
        add_byte(PngFirst);
        send_file(1'b1);
        add_be16({MarkFill, MarkSoi});
        add_byte(MarkFill);
        add_byte(MarkFill);
        add_byte(MarkFill);
        add_byte(MarkTem);
        add_be16({MarkFill, MarkRst0});
        add_be16({MarkFill, 8'hD7});
        add_be16({MarkFill, MarkSoi});
        gen_segment(MarkDht, 16'd4);
        gen_segment(MarkJpg, 16'd2);
        gen_segment(MarkDac, 16'd3);
        gen_segment(8'hE0, 16'd5);
        gen_sof(MarkSof0, 16'd17, 16'd1, 16'd32768);
        add_junk(3);
        send_file(1'b1);
        add_be16({MarkFill, MarkSoi});
        gen_sof(MarkSof15, 16'd7, 16'hFFFF, 16'hFFFF);
        send_file(1'b1);
        add_be16({MarkFill, MarkSoi});
        gen_sof(8'hC2, 16'd11, 16'd240, 16'd320);
        send_file(1'b1);
        add_be16({MarkFill, MarkSoi});
        gen_sof(8'hC1, 16'd8, 16'd0, 16'd1);
        send_file(1'b1);
        add_be32({MarkFill, MarkSoi, MarkFill, MarkEoi});
        send_file(1'b1);
        add_be32({MarkFill, MarkSoi, MarkFill, MarkSos});
        send_file(1'b1);
        add_be32({MarkFill, MarkSoi, MarkFill, 8'hE1});
        add_be16(16'd1);
        send_file(1'b1);
        add_be32({MarkFill, MarkSoi, MarkFill, 8'hE1});
        add_be16(16'd0);
        send_file(1'b1);
        add_be32({MarkFill, MarkSoi, MarkFill, 8'hC1});
        add_be16(16'd6);
        add_junk(2);
        send_file(1'b1);
        add_be16({MarkFill, 8'h00});
        send_file(1'b1);
        add_be16({MarkFill, MarkSoi});
        add_byte(8'h00);
        send_file(1'b1);
        // A start flag in the middle of a file throws away the partial header.
        gen_png(32'd7, 32'd9, 32'd13, -1);
        while (file_bytes.size() > 10) void'(file_bytes.pop_back());
        send_file(1'b1);
        wait_all_results();

        while (sb.live_bytes < ByteTarget) begin
            burst = ($urandom_range(0, 3) == 0);
            r = $urandom_range(0, 99);
            if (r < 35) begin
                bad_at = -1;
                if ($urandom_range(0, 6) == 0) begin
                    bad_at = $urandom_range(0, 19);
                    if (bad_at >= 8) bad_at += 4;
                end
                gen_png(pick_dim32(), pick_dim32(),
                        ($urandom_range(0, 7) == 0) ? $urandom() : 32'd13, bad_at);
            end else if (r < 90) begin
                gen_jpeg($urandom_range(0, 6) == 0);
            end else begin
                add_junk($urandom_range(1, 6));
            end
            if ($urandom_range(0, 3) == 0) add_junk($urandom_range(1, 3));
            if ($urandom_range(0, 19) == 0) begin
                keep = $urandom_range(1, file_bytes.size());
                while (file_bytes.size() > keep) void'(file_bytes.pop_back());
            end
            send_file(1'b1);
            if (!paused && sb.live_bytes >= ByteTarget / 2) begin
                paused = 1'b1;
                wait_all_results();
            end
        end

        draining = 1'b1;
        wait_all_results();
        repeat (8) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// File: sim.f
sv/idhp_pkg.sv
sv/idhp_in_reg.sv
sv/idhp_parser.sv
sv/idhp_out_reg.sv
sv/image_header_dims_probe_top.sv
test/testbench.sv
